// File: hw/rtl/pl0sm_pkg.sv
`default_nettype none

package pl0sm_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int AW = 6;
	localparam int PCW = 7;
	localparam int SPW = 7;
	localparam int DW = 32;
	localparam int IW = 34;

	localparam logic [3:0] OP_LIT = 4'd1;
	localparam logic [3:0] OP_OPR = 4'd2;
	localparam logic [3:0] OP_LOD = 4'd3;
	localparam logic [3:0] OP_STO = 4'd4;
	localparam logic [3:0] OP_CAL = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_JMP = 4'd7;
	localparam logic [3:0] OP_JPC = 4'd8;
	localparam logic [3:0] OP_SYS = 4'd9;

	localparam logic signed [15:0] OPR_RET = 16'sd0;
	localparam logic signed [15:0] OPR_NEG = 16'sd1;
	localparam logic signed [15:0] OPR_ADD = 16'sd2;
	localparam logic signed [15:0] OPR_SUB = 16'sd3;
	localparam logic signed [15:0] OPR_MUL = 16'sd4;
	localparam logic signed [15:0] OPR_DIV = 16'sd5;
	localparam logic signed [15:0] OPR_ODD = 16'sd6;
	localparam logic signed [15:0] OPR_MOD = 16'sd7;
	localparam logic signed [15:0] OPR_EQL = 16'sd8;
	localparam logic signed [15:0] OPR_NEQ = 16'sd9;
	localparam logic signed [15:0] OPR_LSS = 16'sd10;
	localparam logic signed [15:0] OPR_LEQ = 16'sd11;
	localparam logic signed [15:0] OPR_GTR = 16'sd12;
	localparam logic signed [15:0] OPR_GEQ = 16'sd13;

	localparam logic signed [15:0] SYS_OUT = 16'sd1;
	localparam logic signed [15:0] SYS_IN = 16'sd2;
	localparam logic signed [15:0] SYS_HALT = 16'sd3;

	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_RANGE = 2'd1;
	localparam logic [1:0] FAULT_DIV0 = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_WALK, S_WCAP, S_CHK, S_RD, S_CAP, S_EXEC, S_DIV, S_WB, S_CALW, S_OUT
	} state_t;

	typedef struct packed {
		logic en;
		logic [AW-1:0] addr;
		logic [DW-1:0] data;
	} ram_wr_t;

	function automatic logic in_stack(input logic signed [IW-1:0] idx);
		return (idx >= 0) && (idx < IW'(STACK_DEPTH));
	endfunction

	function automatic logic sp_ok(input logic signed [IW-1:0] idx);
		return (idx >= -1) && (idx < IW'(STACK_DEPTH));
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pl0sm_stack_ram.sv
`default_nettype none

module pl0sm_stack_ram (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pl0sm_pkg::ram_wr_t     wr,
	input  wire logic [pl0sm_pkg::AW-1:0] raddr,
	output logic [pl0sm_pkg::DW-1:0]    rdata
);

	logic [pl0sm_pkg::DW-1:0] mem [pl0sm_pkg::STACK_DEPTH];
	logic [pl0sm_pkg::STACK_DEPTH-1:0] vld_q;
	logic [pl0sm_pkg::DW-1:0] rdata_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/pl0sm_div.sv
`default_nettype none

module pl0sm_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [pl0sm_pkg::DW-1:0] dividend,
	input  wire logic [pl0sm_pkg::DW-1:0] divisor,
	output logic                          done,
	output logic [pl0sm_pkg::DW-1:0]      quotient,
	output logic [pl0sm_pkg::DW-1:0]      remainder
);

	localparam int CW = $clog2(pl0sm_pkg::DW);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [pl0sm_pkg::DW-1:0] q_q;
	logic [pl0sm_pkg::DW-1:0] rem_q;
	logic [pl0sm_pkg::DW-1:0] d_q;
	logic sq_q;
	logic sr_q;
	logic [pl0sm_pkg::DW+1:0] trial;

	assign trial = {1'b0, rem_q, q_q[pl0sm_pkg::DW-1]} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(pl0sm_pkg::DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle on magnitudes
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend[pl0sm_pkg::DW-1] ? -dividend : dividend;
			d_q <= divisor[pl0sm_pkg::DW-1] ? -divisor : divisor;
			rem_q <= '0;
			sq_q <= dividend[pl0sm_pkg::DW-1] ^ divisor[pl0sm_pkg::DW-1];
			sr_q <= dividend[pl0sm_pkg::DW-1];
		end else if (busy_q) begin
			if (!trial[pl0sm_pkg::DW+1]) begin
				rem_q <= trial[pl0sm_pkg::DW-1:0];
				q_q <= {q_q[pl0sm_pkg::DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[pl0sm_pkg::DW-2:0], q_q[pl0sm_pkg::DW-1]};
				q_q <= {q_q[pl0sm_pkg::DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = sq_q ? -q_q : q_q;
	assign remainder = sr_q ? -rem_q : rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/pl0_stack_machine_step.sv
// channel | valid     | stall     | payload
// --------+-----------+-----------+-----------------------------------------------
// in      | in_valid  | in_stall  | opcode, level, operand, read_value
// out     | out_valid | out_stall | next_pc, stack_ptr, base_ptr, print_valid,
//         |           |           | print_value, halted, fault
//
// One instruction at a time: it walks the static links, then reads the stack operands,
// and executes once any read is done; a two-operand OPR that writes back adds a
// write-back step, CAL writes four link words, DIV and MOD wait on the serial divider.
// The stack memory, one read port and one write port, sets the pace.
// Reset clears the control registers and the per-entry valid bits; no clearing pass.
// A new beat is taken while a result waits in the output register.
`default_nettype none

module pl0_stack_machine_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  opcode,
	input  wire logic [3:0]  level,
	input  wire logic signed [15:0] operand,
	input  wire logic signed [31:0] read_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       next_pc,
	output logic signed [6:0] stack_ptr,
	output logic [5:0]       base_ptr,
	output logic             print_valid,
	output logic signed [31:0] print_value,
	output logic             halted,
	output logic [1:0]       fault
);

	localparam int AW = pl0sm_pkg::AW;
	localparam int DW = pl0sm_pkg::DW;
	localparam int IW = pl0sm_pkg::IW;
	localparam int PCW = pl0sm_pkg::PCW;
	localparam int SPW = pl0sm_pkg::SPW;

	pl0sm_pkg::state_t state_q, state_d;

	logic [3:0] op_q;
	logic signed [15:0] m_q;
	logic [DW-1:0] rdv_q;
	logic [3:0] cnt_q, cnt_d;
	logic signed [IW-1:0] b_q, b_d;
	logic [1:0] rk_q, rk_d;
	logic [1:0] nr_q, nr_d;
	logic [1:0] wk_q, wk_d;
	logic [DW-1:0] ra_q, rb_q, rc_q;
	logic [DW-1:0] res_q, res_d;

	logic [PCW-1:0] pc_q, pc_d;
	logic signed [SPW-1:0] sp_q, sp_d;
	logic [AW-1:0] bp_q, bp_d;
	logic halt_q, halt_d;
	logic pv_q, pv_d;
	logic [DW-1:0] pval_q, pval_d;
	logic [1:0] fault_q, fault_d;

	logic out_valid_q;
	logic [PCW-1:0] out_pc_q;
	logic signed [SPW-1:0] out_sp_q;
	logic [AW-1:0] out_bp_q;
	logic out_pv_q;
	logic [DW-1:0] out_pval_q;
	logic out_halt_q;
	logic [1:0] out_fault_q;

	pl0sm_pkg::ram_wr_t wr;
	logic [AW-1:0] raddr;
	logic [DW-1:0] rdata;

	logic div_start;
	logic div_done;
	logic [DW-1:0] div_quo, div_rem;

	logic accept;
	logic out_load;
	logic [PCW-1:0] npc;
	logic signed [IW-1:0] spx, bpx, mx, bm, rdi;
	logic is_ret, is_unary, is_bin;
	logic signed [DW-1:0] ra_s, rb_s;
	logic [2*DW-1:0] prod;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != pl0sm_pkg::S_IDLE);
	assign out_load = (state_q == pl0sm_pkg::S_OUT) && (!out_valid_q || !out_stall);

	assign npc = pc_q + 1'b1;
	assign spx = IW'(sp_q);
	assign bpx = IW'(bp_q);
	assign mx = IW'(m_q);
	assign bm = b_q + mx;
	assign ra_s = ra_q;
	assign rb_s = rb_q;
	assign prod = ra_q * rb_q;

	assign is_ret = (m_q == pl0sm_pkg::OPR_RET);
	assign is_unary = (m_q == pl0sm_pkg::OPR_NEG) || (m_q == pl0sm_pkg::OPR_ODD);
	assign is_bin = (m_q >= pl0sm_pkg::OPR_ADD) && (m_q <= pl0sm_pkg::OPR_GEQ) && !is_unary;

	// read address of the k-th operand fetch, or of the static link during the walk
	always_comb begin
		rdi = spx;
		if (op_q == pl0sm_pkg::OP_OPR && is_ret) begin
			unique case (rk_q)
				2'd0: rdi = spx;
				2'd1: rdi = bpx + IW'(1);
				default: rdi = bpx + IW'(2);
			endcase
		end else if (op_q == pl0sm_pkg::OP_OPR) begin
			rdi = (rk_q == 2'd0 && !is_unary) ? spx - IW'(1) : spx;
		end else if (op_q == pl0sm_pkg::OP_LOD) begin
			rdi = bm;
		end
		raddr = (state_q == pl0sm_pkg::S_WALK) ? b_q[AW-1:0] : rdi[AW-1:0];
	end

	pl0sm_stack_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	pl0sm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (ra_q),
		.divisor   (rb_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pl0sm_pkg::S_IDLE;
			cnt_q <= '0;
			rk_q <= '0;
			nr_q <= '0;
			wk_q <= '0;
			pc_q <= '0;
			sp_q <= -SPW'(1);
			bp_q <= '0;
			halt_q <= 1'b0;
			pv_q <= 1'b0;
			fault_q <= pl0sm_pkg::FAULT_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rk_q <= rk_d;
			nr_q <= nr_d;
			wk_q <= wk_d;
			pc_q <= pc_d;
			sp_q <= sp_d;
			bp_q <= bp_d;
			halt_q <= halt_d;
			pv_q <= pv_d;
			fault_q <= fault_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			m_q <= operand;
			rdv_q <= read_value;
		end
		b_q <= b_d;
		res_q <= res_d;
		pval_q <= pval_d;
		if (state_q == pl0sm_pkg::S_CAP) begin
			unique case (rk_q)
				2'd0: ra_q <= rdata;
				2'd1: rb_q <= rdata;
				default: rc_q <= rdata;
			endcase
		end
		if (out_load) begin
			out_pc_q <= pc_q;
			out_sp_q <= sp_q;
			out_bp_q <= bp_q;
			out_pv_q <= pv_q;
			out_pval_q <= pval_q;
			out_halt_q <= halt_q;
			out_fault_q <= fault_q;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		b_d = b_q;
		rk_d = rk_q;
		nr_d = nr_q;
		wk_d = wk_q;
		res_d = res_q;
		pc_d = pc_q;
		sp_d = sp_q;
		bp_d = bp_q;
		halt_d = halt_q;
		pv_d = pv_q;
		pval_d = pval_q;
		fault_d = fault_q;
		wr = '0;
		div_start = 1'b0;

		unique case (state_q)
			pl0sm_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = pl0sm_pkg::S_WALK;
					b_d = bpx;
					cnt_d = (!halt_q && (opcode == pl0sm_pkg::OP_LOD
						|| opcode == pl0sm_pkg::OP_STO || opcode == pl0sm_pkg::OP_CAL))
						? level : 4'd0;
					pv_d = 1'b0;
					pval_d = '0;
					fault_d = pl0sm_pkg::FAULT_NONE;
				end
			end

			// follow one static link at a time: read it in S_WALK, take it in S_WCAP
			pl0sm_pkg::S_WALK: begin
				if (cnt_q == 4'd0) begin
					state_d = pl0sm_pkg::S_CHK;
				end else if (!pl0sm_pkg::in_stack(b_q)) begin
					fault_d = pl0sm_pkg::FAULT_RANGE;
					state_d = pl0sm_pkg::S_OUT;
				end else begin
					state_d = pl0sm_pkg::S_WCAP;
				end
			end

			pl0sm_pkg::S_WCAP: begin
				b_d = IW'($signed(rdata));
				cnt_d = cnt_q - 1'b1;
				state_d = pl0sm_pkg::S_WALK;
			end

			pl0sm_pkg::S_CHK: begin
				rk_d = '0;
				wk_d = '0;
				nr_d = 2'd1;
				state_d = pl0sm_pkg::S_OUT;
				if (!halt_q) begin
					unique case (op_q)
						pl0sm_pkg::OP_LIT: begin
							if (!pl0sm_pkg::in_stack(spx + IW'(1))) begin
								fault_d = pl0sm_pkg::FAULT_RANGE;
							end else begin
								wr = '{en: 1'b1, addr: AW'(spx + IW'(1)), data: DW'(mx)};
								sp_d = sp_q + 1'b1;
								pc_d = npc;
							end
						end
						pl0sm_pkg::OP_OPR: begin
							if (is_ret) begin
								if (!pl0sm_pkg::in_stack(spx) || bp_q == '0
									|| !pl0sm_pkg::in_stack(bpx + IW'(2))) begin
									fault_d = pl0sm_pkg::FAULT_RANGE;
								end else begin
									nr_d = 2'd3;
									state_d = pl0sm_pkg::S_RD;
								end
							end else if (is_unary) begin
								if (!pl0sm_pkg::in_stack(spx)) begin
									fault_d = pl0sm_pkg::FAULT_RANGE;
								end else begin
									state_d = pl0sm_pkg::S_RD;
								end
							end else if (is_bin) begin
								if (!pl0sm_pkg::in_stack(spx)
									|| !pl0sm_pkg::in_stack(spx - IW'(1))) begin
									fault_d = pl0sm_pkg::FAULT_RANGE;
								end else begin
									nr_d = 2'd2;
									state_d = pl0sm_pkg::S_RD;
								end
							end else begin
								pc_d = npc;
							end
						end
						pl0sm_pkg::OP_LOD: begin
							if (!pl0sm_pkg::in_stack(bm) || !pl0sm_pkg::in_stack(spx + IW'(1))) begin
								fault_d = pl0sm_pkg::FAULT_RANGE;
							end else begin
								state_d = pl0sm_pkg::S_RD;
							end
						end
						pl0sm_pkg::OP_STO: begin
							if (!pl0sm_pkg::in_stack(bm) || !pl0sm_pkg::in_stack(spx)) begin
								fault_d = pl0sm_pkg::FAULT_RANGE;
							end else begin
								state_d = pl0sm_pkg::S_RD;
							end
						end
						pl0sm_pkg::OP_CAL: begin
							if (!pl0sm_pkg::in_stack(spx + IW'(4))) begin
								fault_d = pl0sm_pkg::FAULT_RANGE;
							end else begin
								state_d = pl0sm_pkg::S_RD;
							end
						end
						pl0sm_pkg::OP_INC: begin
							if (!pl0sm_pkg::sp_ok(spx + mx)) begin
								fault_d = pl0sm_pkg::FAULT_RANGE;
							end else begin
								sp_d = SPW'(spx + mx);
								pc_d = npc;
							end
						end
						pl0sm_pkg::OP_JMP: begin
							pc_d = m_q[PCW-1:0];
						end
						pl0sm_pkg::OP_JPC: begin
							if (!pl0sm_pkg::in_stack(spx)) begin
								fault_d = pl0sm_pkg::FAULT_RANGE;
							end else begin
								state_d = pl0sm_pkg::S_RD;
							end
						end
						pl0sm_pkg::OP_SYS: begin
							if (m_q == pl0sm_pkg::SYS_OUT) begin
								if (!pl0sm_pkg::in_stack(spx)) begin
									fault_d = pl0sm_pkg::FAULT_RANGE;
								end else begin
									state_d = pl0sm_pkg::S_RD;
								end
							end else if (m_q == pl0sm_pkg::SYS_IN) begin
								if (!pl0sm_pkg::in_stack(spx + IW'(1))) begin
									fault_d = pl0sm_pkg::FAULT_RANGE;
								end else begin
									wr = '{en: 1'b1, addr: AW'(spx + IW'(1)), data: rdv_q};
									sp_d = sp_q + 1'b1;
									pc_d = npc;
								end
							end else begin
								if (m_q == pl0sm_pkg::SYS_HALT) begin
									halt_d = 1'b1;
								end
								pc_d = npc;
							end
						end
						default: begin
							pc_d = npc;
						end
					endcase
				end
			end

			pl0sm_pkg::S_RD: begin
				state_d = pl0sm_pkg::S_CAP;
			end

			pl0sm_pkg::S_CAP: begin
				rk_d = rk_q + 1'b1;
				state_d = (rk_q + 1'b1 == nr_q) ? pl0sm_pkg::S_EXEC : pl0sm_pkg::S_RD;
			end

			pl0sm_pkg::S_EXEC: begin
				state_d = pl0sm_pkg::S_OUT;
				unique case (op_q)
					pl0sm_pkg::OP_OPR: begin
						if (is_ret) begin
							if (!pl0sm_pkg::in_stack(IW'(rb_s))) begin
								fault_d = pl0sm_pkg::FAULT_RANGE;
							end else begin
								wr = '{en: 1'b1, addr: AW'(bpx - IW'(1)), data: ra_q};
								sp_d = SPW'(bpx - IW'(1));
								bp_d = rb_q[AW-1:0];
								pc_d = rc_q[PCW-1:0];
							end
						end else if (is_unary) begin
							wr.en = 1'b1;
							wr.addr = sp_q[AW-1:0];
							if (m_q == pl0sm_pkg::OPR_NEG) begin
								wr.data = -ra_q;
							end else begin
								// truncating remainder by two keeps the sign
								wr.data = ra_q[0] ? (ra_q[DW-1] ? '1 : DW'(1)) : '0;
							end
							pc_d = npc;
						end else if (m_q == pl0sm_pkg::OPR_DIV || m_q == pl0sm_pkg::OPR_MOD) begin
							if (rb_q == '0) begin
								fault_d = pl0sm_pkg::FAULT_DIV0;
							end else begin
								div_start = 1'b1;
								state_d = pl0sm_pkg::S_DIV;
							end
						end else begin
							unique case (m_q)
								pl0sm_pkg::OPR_ADD: res_d = ra_q + rb_q;
								pl0sm_pkg::OPR_SUB: res_d = ra_q - rb_q;
								pl0sm_pkg::OPR_MUL: res_d = prod[DW-1:0];
								pl0sm_pkg::OPR_EQL: res_d = DW'(ra_s == rb_s);
								pl0sm_pkg::OPR_NEQ: res_d = DW'(ra_s != rb_s);
								pl0sm_pkg::OPR_LSS: res_d = DW'(ra_s < rb_s);
								pl0sm_pkg::OPR_LEQ: res_d = DW'(ra_s <= rb_s);
								pl0sm_pkg::OPR_GTR: res_d = DW'(ra_s > rb_s);
								default: res_d = DW'(ra_s >= rb_s);
							endcase
							state_d = pl0sm_pkg::S_WB;
						end
					end
					pl0sm_pkg::OP_LOD: begin
						wr = '{en: 1'b1, addr: AW'(spx + IW'(1)), data: ra_q};
						sp_d = sp_q + 1'b1;
						pc_d = npc;
					end
					pl0sm_pkg::OP_STO: begin
						wr = '{en: 1'b1, addr: bm[AW-1:0], data: ra_q};
						sp_d = sp_q - 1'b1;
						pc_d = npc;
					end
					pl0sm_pkg::OP_CAL: begin
						res_d = (sp_q >= 0) ? ra_q : '0;
						state_d = pl0sm_pkg::S_CALW;
					end
					pl0sm_pkg::OP_JPC: begin
						pc_d = (ra_q == '0) ? m_q[PCW-1:0] : npc;
						sp_d = sp_q - 1'b1;
					end
					default: begin
						pv_d = 1'b1;
						pval_d = ra_q;
						sp_d = sp_q - 1'b1;
						pc_d = npc;
					end
				endcase
			end

			pl0sm_pkg::S_DIV: begin
				if (div_done) begin
					res_d = (m_q == pl0sm_pkg::OPR_MOD) ? div_rem : div_quo;
					state_d = pl0sm_pkg::S_WB;
				end
			end

			pl0sm_pkg::S_WB: begin
				wr = '{en: 1'b1, addr: AW'(spx - IW'(1)), data: res_q};
				sp_d = sp_q - 1'b1;
				pc_d = npc;
				state_d = pl0sm_pkg::S_OUT;
			end

			// lay down static link, dynamic link, return address, parameter
			pl0sm_pkg::S_CALW: begin
				wr.en = 1'b1;
				wr.addr = AW'(spx + IW'(1) + IW'(wk_q));
				unique case (wk_q)
					2'd0: wr.data = b_q[DW-1:0];
					2'd1: wr.data = DW'(bp_q);
					2'd2: wr.data = DW'(npc);
					default: wr.data = res_q;
				endcase
				wk_d = wk_q + 1'b1;
				if (wk_q == 2'd3) begin
					bp_d = AW'(spx + IW'(1));
					pc_d = m_q[PCW-1:0];
					state_d = pl0sm_pkg::S_OUT;
				end
			end

			pl0sm_pkg::S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = pl0sm_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = pl0sm_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign next_pc = out_pc_q;
	assign stack_ptr = out_sp_q;
	assign base_ptr = out_bp_q;
	assign print_valid = out_pv_q;
	assign print_value = out_pval_q;
	assign halted = out_halt_q;
	assign fault = out_fault_q;

`ifndef NO_ASSERTIONS
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag dropped");

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q >= -SPW'(1))
		else $error("stack pointer below empty");

	a_fault_no_print: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pl0sm_pkg::S_OUT && fault_q != pl0sm_pkg::FAULT_NONE) |-> !pv_q)
		else $error("print on faulting instruction");

	a_div_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == pl0sm_pkg::S_DIV)
		else $error("divider finished outside divide wait");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == pl0sm_pkg::S_CHK || state_q == pl0sm_pkg::S_EXEC
			|| state_q == pl0sm_pkg::S_WB || state_q == pl0sm_pkg::S_CALW))
		else $error("stack write in a read state");
`endif

endmodule

`default_nettype wire
